/* sv/i2p_pkg.sv */
package i2p_pkg;

	// Operator stack geometry.
	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	// Input token kinds.
	localparam logic [2:0] CMD_OPERAND  = 3'd0;
	localparam logic [2:0] CMD_OPERATOR = 3'd1;
	localparam logic [2:0] CMD_OPEN     = 3'd2;
	localparam logic [2:0] CMD_CLOSE    = 3'd3;
	localparam logic [2:0] CMD_END      = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_OPERAND  = 2'd0;
	localparam logic [1:0] KIND_OPERATOR = 2'd1;
	localparam logic [1:0] KIND_STATUS   = 2'd2;

	// Error codes carried by status words.
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_CLOSE    = 2'd2;
	localparam logic [1:0] ERR_OPEN     = 2'd3;

	// Stack entry that marks an open parenthesis.
	localparam logic [2:0] PAREN_MARK = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       tok_load;
		logic       rd_en;
		logic       pop;
		logic       push_op;
		logic       push_paren;
		logic       emit;
		logic [1:0] emit_kind;
		logic       err_load;
		logic [1:0] err_val;
		logic       flush;
	} i2p_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic count_one;
		logic count_full;
		logic top_paren;
		logic top_pops;
		logic pend_valid;
		logic slot_free;
	} i2p_stat_t;

	// Multiply and divide outrank add and subtract.
	function automatic logic prec_hi(input logic [1:0] code);
		return code[1];
	endfunction

endpackage

/* sv/i2p_dpath.sv */
module i2p_dpath
	import i2p_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  i2p_cmd_t    cmd_bus,
	output i2p_stat_t   stat,
	input  logic [1:0]  op_code,
	input  logic [31:0] operand_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [1:0]  out_op,
	output logic [31:0] out_value,
	output logic [1:0]  out_error,
	output logic        out_last
);

	logic [2:0]       stack_mem [STACK_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [2:0]       rd_data_q;
	logic [1:0]       tok_op_q;
	logic [1:0]       err_q;

	logic             pend_valid_q;
	logic [1:0]       pend_kind_q;
	logic [1:0]       pend_op_q;
	logic [31:0]      pend_value_q;
	logic [1:0]       pend_error_q;

	logic             out_valid_q;
	logic [1:0]       out_kind_q;
	logic [1:0]       out_op_q;
	logic [31:0]      out_value_q;
	logic [1:0]       out_error_q;
	logic             out_last_q;

	logic [CNT_W-1:0] rd_cnt;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic             slot_free;
	logic             emit_move;
	logic             flush_move;
	logic [1:0]       new_kind;
	logic [1:0]       new_op;
	logic [31:0]      new_value;
	logic [1:0]       new_error;

	// The read address is the top entry, or the one below it when the top
	// is popped in the same cycle.
	assign rd_cnt  = cmd_bus.pop ? count_q - CNT_W'(2) : count_q - CNT_W'(1);
	assign rd_addr = rd_cnt[ADDR_W-1:0];
	assign wr_addr = count_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd_bus.push_op) begin
			stack_mem[wr_addr] <= {1'b0, tok_op_q};
		end else if (cmd_bus.push_paren) begin
			stack_mem[wr_addr] <= PAREN_MARK;
		end
		if (cmd_bus.rd_en) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd_bus.push_op || cmd_bus.push_paren) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd_bus.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_bus.tok_load) begin
			tok_op_q <= op_code;
		end
		if (cmd_bus.err_load) begin
			err_q <= cmd_bus.err_val;
		end
	end

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		new_kind  = cmd_bus.emit_kind;
		new_op    = '0;
		new_value = '0;
		new_error = ERR_NONE;
		case (cmd_bus.emit_kind)
			KIND_OPERAND:  new_value = operand_value;
			KIND_OPERATOR: new_op    = rd_data_q[1:0];
			KIND_STATUS:   new_error = err_q;
			default:       new_kind  = KIND_STATUS;
		endcase
	end

	// A new result pushes the held one out as a non-final word; a flush sends
	// the held one as the final word of its token.
	assign emit_move  = cmd_bus.emit && pend_valid_q;
	assign flush_move = cmd_bus.flush && pend_valid_q && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd_bus.emit) begin
			pend_valid_q <= 1'b1;
		end else if (flush_move) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_bus.emit) begin
			pend_kind_q  <= new_kind;
			pend_op_q    <= new_op;
			pend_value_q <= new_value;
			pend_error_q <= new_error;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_move || flush_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_move || flush_move) begin
			out_kind_q  <= pend_kind_q;
			out_op_q    <= pend_op_q;
			out_value_q <= pend_value_q;
			out_error_q <= pend_error_q;
			out_last_q  <= flush_move;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_op    = out_op_q;
	assign out_value = out_value_q;
	assign out_error = out_error_q;
	assign out_last  = out_last_q;

	assign stat.count_zero = (count_q == '0);
	assign stat.count_one  = (count_q == CNT_W'(1));
	assign stat.count_full = (count_q == CNT_W'(STACK_DEPTH));
	assign stat.top_paren  = (rd_data_q == PAREN_MARK);
	assign stat.top_pops   = (rd_data_q != PAREN_MARK) &&
		(prec_hi(rd_data_q[1:0]) || !prec_hi(tok_op_q));
	assign stat.pend_valid = pend_valid_q;
	assign stat.slot_free  = slot_free;

endmodule

/* sv/i2p_ctrl.sv */
module i2p_ctrl
	import i2p_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic [2:0] cmd,
	input  i2p_stat_t stat,
	output i2p_cmd_t  cmd_bus
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHK   = 3'd1;
	localparam logic [2:0] S_PUSH  = 3'd2;
	localparam logic [2:0] S_ERR   = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] tok_cmd_q;
	logic       accept;
	logic       stall;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign stall    = stat.pend_valid && !stat.slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_cmd_q <= cmd;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_bus = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_bus.tok_load = 1'b1;
					cmd_bus.err_load = 1'b1;
					case (cmd)
						CMD_OPERAND: begin
							cmd_bus.emit      = 1'b1;
							cmd_bus.emit_kind = KIND_OPERAND;
							state_d           = S_FLUSH;
						end
						CMD_OPERATOR: begin
							cmd_bus.err_val = ERR_OVERFLOW;
							if (stat.count_zero) begin
								state_d = S_PUSH;
							end else begin
								cmd_bus.rd_en = 1'b1;
								state_d       = S_CHK;
							end
						end
						CMD_OPEN: begin
							cmd_bus.err_val = ERR_OVERFLOW;
							if (stat.count_full) begin
								state_d = S_ERR;
							end else begin
								cmd_bus.push_paren = 1'b1;
							end
						end
						CMD_CLOSE: begin
							cmd_bus.err_val = ERR_CLOSE;
							if (stat.count_zero) begin
								state_d = S_ERR;
							end else begin
								cmd_bus.rd_en = 1'b1;
								state_d       = S_CHK;
							end
						end
						CMD_END: begin
							cmd_bus.err_val = ERR_NONE;
							if (stat.count_zero) begin
								state_d = S_ERR;
							end else begin
								cmd_bus.rd_en = 1'b1;
								state_d       = S_CHK;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_CHK: begin
				if (!stall) begin
					case (tok_cmd_q)
						CMD_OPERATOR: begin
							if (!stat.top_pops) begin
								if (stat.count_full) begin
									state_d = S_ERR;
								end else begin
									cmd_bus.push_op = 1'b1;
									state_d         = S_FLUSH;
								end
							end else begin
								cmd_bus.emit      = 1'b1;
								cmd_bus.emit_kind = KIND_OPERATOR;
								cmd_bus.pop       = 1'b1;
								if (stat.count_one) begin
									state_d = S_PUSH;
								end else begin
									cmd_bus.rd_en = 1'b1;
								end
							end
						end
						CMD_CLOSE: begin
							cmd_bus.pop = 1'b1;
							if (stat.top_paren) begin
								state_d = S_FLUSH;
							end else begin
								cmd_bus.emit      = 1'b1;
								cmd_bus.emit_kind = KIND_OPERATOR;
								if (stat.count_one) begin
									state_d = S_ERR;
								end else begin
									cmd_bus.rd_en = 1'b1;
								end
							end
						end
						default: begin
							// End marker: drain everything, dropping parens.
							cmd_bus.pop = 1'b1;
							if (stat.top_paren) begin
								cmd_bus.err_load = 1'b1;
								cmd_bus.err_val  = ERR_OPEN;
							end else begin
								cmd_bus.emit      = 1'b1;
								cmd_bus.emit_kind = KIND_OPERATOR;
							end
							if (stat.count_one) begin
								state_d = S_ERR;
							end else begin
								cmd_bus.rd_en = 1'b1;
							end
						end
					endcase
				end
			end
			S_PUSH: begin
				cmd_bus.push_op = 1'b1;
				state_d         = S_FLUSH;
			end
			S_ERR: begin
				if (!stall) begin
					cmd_bus.emit      = 1'b1;
					cmd_bus.emit_kind = KIND_STATUS;
					state_d           = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd_bus.flush = 1'b1;
				if (!stat.pend_valid || stat.slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* sv/infix_to_postfix_converter.sv */
// Shunting-yard infix to postfix converter.
// The input channel (in_valid/in_ready) takes one infix token per word:
// cmd selects operand, operator, open paren, close paren or end marker,
// with op_code and operand_value as the token's payload. The output
// channel (out_valid/out_ready) delivers postfix words in order; out_last
// marks the final word that a token releases. Tokens that release nothing
// (a pushed operator or open paren, or an unused cmd code) give no word.
// Each result is held one step in a pending register so that out_last is
// known when the word moves into the output register.
// Throughput is one token at a time. An operand's word passes through the
// pending register and then the output register. Stack pops go one at a
// time, since the operator stack is a memory with one registered read
// port; an operator, close paren or end marker steps through its pops in
// the check state, and an open paren is pushed while the controller stays
// idle. A status word is emitted from an error state of its own.
// Reset empties the stack, the pending register and the output register;
// stack contents are not cleared, as only entries below the count are ever read.
// When the receiver stalls, the output register holds its word and the
// controller waits before releasing any further word of the token.
module infix_to_postfix_converter
	import i2p_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [1:0]  op_code,
	input  logic signed [31:0] operand_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [1:0]  out_op,
	output logic signed [31:0] out_value,
	output logic [1:0]  out_error,
	output logic        out_last
);

	i2p_cmd_t  cmd_bus;
	i2p_stat_t stat;
	logic [31:0] value_raw;

	// The controller sequences pushes, pops and emits; the datapath holds
	// the stack memory, its count, and the pending and output registers.
	i2p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat),
		.cmd_bus  (cmd_bus)
	);

	i2p_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_bus       (cmd_bus),
		.stat          (stat),
		.op_code       (op_code),
		.operand_value (operand_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_kind      (out_kind),
		.out_op        (out_op),
		.out_value     (value_raw),
		.out_error     (out_error),
		.out_last      (out_last)
	);

	assign out_value = signed'(value_raw);

endmodule
